// ===== src/lpsa_pkg.sv =====
package lpsa_pkg;

  // fixed field widths
  localparam int KEY_W  = 31;
  localparam int CFG_W  = 11;
  localparam int IDX_W  = 10;

  // used-map row layout: one row of bits per memory word
  localparam int ROW_LG = 5;
  localparam int ROW_W  = 1 << ROW_LG;

  // home-slot divider: key bits consumed per cycle
  localparam int DIG_W  = 4;

  localparam int DEF_MAX_SLOTS = 1024;
  localparam int QUEUE_DEPTH   = 2;

  // configuration
  localparam int                 REG_IDX_W      = 1;
  localparam logic [REG_IDX_W-1:0] REG_TABLE_SIZE = 1'b0;
  localparam logic [CFG_W-1:0]   SIZE_RESET     = 11'd1024;

  typedef struct packed {
    logic [KEY_W-1:0] user_key;
    logic             end_of_batch;
  } lpsa_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] slot_index;
    logic             table_full;
  } lpsa_out_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [CFG_W-1:0] home;
    logic [CFG_W-1:0] size;
    logic             end_of_batch;
  } lpsa_job_t;

endpackage

// ===== src/lpsa_fifo.sv =====
module lpsa_fifo
  import lpsa_pkg::*;
#(
  parameter int WIDTH = 1,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== src/lpsa_front.sv =====
module lpsa_front
  import lpsa_pkg::*;
#(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  lpsa_in_t         in_data,
  output logic             full,
  input  logic [CFG_W-1:0] cfg_size,
  output lpsa_job_t        job,
  output logic             job_push,
  input  logic             job_full
);

  localparam int EMAX   = (MAX_SLOTS < (1 << CFG_W) - 1) ? MAX_SLOTS : (1 << CFG_W) - 1;
  localparam int DIGITS = (KEY_W + DIG_W - 1) / DIG_W;
  localparam int PAD_W  = DIGITS * DIG_W;
  localparam int CNT_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam logic [CFG_W-1:0] EMAX_C = CFG_W'(EMAX);

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } fstate_t;

  fstate_t          state_r;
  logic [PAD_W-1:0] key_r;
  logic [CFG_W-1:0] rem_r, rem_nxt;
  logic [CFG_W-1:0] size_r, eff_size;
  logic             eob_r;
  logic [CNT_W-1:0] cnt_r;

  // zero reads as one, oversize saturates
  always_comb begin
    if (cfg_size == '0) begin
      eff_size = CFG_W'(1);
    end else if (cfg_size > EMAX_C) begin
      eff_size = EMAX_C;
    end else begin
      eff_size = cfg_size;
    end
  end

  // restoring remainder, DIG_W key bits a cycle
  always_comb begin
    logic [CFG_W:0] t;
    rem_nxt = rem_r;
    for (int k = 0; k < DIG_W; k++) begin
      t = {rem_nxt, key_r[PAD_W-1-k]};
      if (t >= {1'b0, size_r}) begin
        t = t - {1'b0, size_r};
      end
      rem_nxt = t[CFG_W-1:0];
    end
  end

  assign full     = (state_r != F_IDLE);
  assign job_push = (state_r == F_PUSH);
  assign job      = '{home: rem_r, size: size_r, end_of_batch: eob_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (push) begin
            key_r   <= PAD_W'(in_data.user_key);
            eob_r   <= in_data.end_of_batch;
            size_r  <= eff_size;
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= F_DIV;
          end
        end
        F_DIV: begin
          key_r <= key_r << DIG_W;
          rem_r <= rem_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(DIGITS - 1)) begin
            state_r <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!job_full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== src/lpsa_back.sv =====
module lpsa_back
  import lpsa_pkg::*;
#(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  lpsa_job_t job,
  input  logic      job_empty,
  output logic      job_pop,
  output lpsa_out_t res,
  output logic      res_push,
  input  logic      res_full
);

  localparam int EMAX  = (MAX_SLOTS < (1 << CFG_W) - 1) ? MAX_SLOTS : (1 << CFG_W) - 1;
  localparam int NROWS = (EMAX + ROW_W - 1) / ROW_W;
  localparam int RI_W  = (NROWS > 1) ? $clog2(NROWS) : 1;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_EVAL,
    B_DONE
  } bstate_t;

  bstate_t           state_r;
  logic [ROW_W-1:0]  mem [NROWS];
  logic [ROW_W-1:0]  rdata_r;
  logic [NROWS-1:0]  rv_r;
  logic [RI_W-1:0]   row_r, last_row_r;
  logic [ROW_LG-1:0] lo_r, last_bit_r;
  logic              pass_r, eob_r;
  lpsa_out_t         res_r;

  logic [CFG_W-1:0]  szm1;
  logic [ROW_W-1:0]  row_bits, free_bits, new_row;
  logic [ROW_LG-1:0] idx;
  logic              found, at_end;

  assign szm1     = job.size - 1'b1;
  assign job_pop  = (state_r == B_IDLE) && !job_empty;
  assign res_push = (state_r == B_DONE);
  assign res      = res_r;
  assign at_end   = (row_r == last_row_r);

  // a row never written since the last clear reads as all free
  assign row_bits = rv_r[row_r] ? rdata_r : '0;

  always_comb begin
    for (int i = 0; i < ROW_W; i++) begin
      free_bits[i] = !row_bits[i] && (ROW_LG'(i) >= lo_r) &&
                     (!at_end || (ROW_LG'(i) <= last_bit_r));
    end
  end

  // lowest free bit
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        found = 1'b1;
        idx   = ROW_LG'(i);
      end
    end
  end

  assign new_row = row_bits | (ROW_W'(1) << idx);

  always_ff @(posedge clk) begin
    if (state_r == B_READ) begin
      rdata_r <= mem[row_r];
    end
    if ((state_r == B_EVAL) && found) begin
      mem[row_r] <= new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      rv_r    <= '0;
    end else begin
      case (state_r)
        B_IDLE: begin
          if (!job_empty) begin
            row_r      <= RI_W'(job.home >> ROW_LG);
            lo_r       <= job.home[ROW_LG-1:0];
            last_row_r <= RI_W'(szm1 >> ROW_LG);
            last_bit_r <= szm1[ROW_LG-1:0];
            pass_r     <= 1'b0;
            eob_r      <= job.end_of_batch;
            state_r    <= B_READ;
          end
        end
        B_READ: begin
          state_r <= B_EVAL;
        end
        B_EVAL: begin
          if (found) begin
            rv_r[row_r]      <= 1'b1;
            res_r.slot_index <= IDX_W'({row_r, idx});
            res_r.table_full <= 1'b0;
            state_r          <= B_DONE;
          end else if (at_end && pass_r) begin
            res_r.slot_index <= '0;
            res_r.table_full <= 1'b1;
            state_r          <= B_DONE;
          end else begin
            row_r   <= at_end ? '0 : row_r + 1'b1;
            pass_r  <= pass_r || at_end;
            lo_r    <= '0;
            state_r <= B_READ;
          end
        end
        B_DONE: begin
          if (!res_full) begin
            if (eob_r) begin
              rv_r <= '0;
            end
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== src/linear_probe_slot_allocator_top.sv =====
// Path: the front registers a request and works out its home slot, the job queue passes it on,
//   and the back reads and evaluates one 32-slot row at a time before its result is queued.
// Throughput: the front takes no new request until it has handed off the last (home-slot divider
//   at 4 key bits a cycle); a long probe walk makes the back the limit.
// Reset (rst_n, synchronous, active low): all slots free, table_size = 1024, queues empty.
// End of batch clears the used map by resetting the per-row valid bits; no clearing pass.
module linear_probe_slot_allocator_top
  import lpsa_pkg::*;
#(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
  input  logic        clk,
  input  logic        rst_n,
  // request side
  input  logic        push,
  input  lpsa_in_t    in_data,
  output logic        full,
  // result side
  output logic        empty,
  input  logic        pop,
  output lpsa_out_t   out_data,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int JOB_W = $bits(lpsa_job_t);
  localparam int RES_W = $bits(lpsa_out_t);

  logic [CFG_W-1:0] table_size_r;
  logic             cfg_wr;

  lpsa_job_t        job_in, job_out;
  logic [JOB_W-1:0] job_q_dout;
  logic             job_push, job_full, job_pop, job_empty;

  lpsa_out_t        res_in;
  logic [RES_W-1:0] res_q_dout;
  logic             res_push, res_full;

  // --- configuration register ---
  // register index is paddr[2]; writes to the unused word are dropped
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2:2] == REG_TABLE_SIZE);
  assign prdata = (paddr[2:2] == REG_TABLE_SIZE) ? 32'(table_size_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= SIZE_RESET;
    end else if (cfg_wr) begin
      table_size_r <= pwdata[CFG_W-1:0];
    end
  end

  // --- front: accept request, clamp size, work out home slot ---
  lpsa_front #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_data  (in_data),
    .full     (full),
    .cfg_size (table_size_r),
    .job      (job_in),
    .job_push (job_push),
    .job_full (job_full)
  );

  // --- short queue between front and back ---
  lpsa_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .din   (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .dout  (job_q_dout),
    .empty (job_empty)
  );

  assign job_out = lpsa_job_t'(job_q_dout);

  // --- back: probe the used map row by row, mark and report ---
  lpsa_back #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job_out),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .res       (res_in),
    .res_push  (res_push),
    .res_full  (res_full)
  );

  // --- result queue: the back runs on while a result waits to be popped ---
  lpsa_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_q_dout),
    .empty (empty)
  );

  assign out_data = lpsa_out_t'(res_q_dout);

endmodule
